>>> src/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the broadcast ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int unsigned COUNT_W     = 3;
   localparam int unsigned READS_W     = 3;
   localparam int unsigned RID_W       = 2;
   localparam int unsigned FIELD_W     = 32;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned SLOT_USED_W = 4;

   localparam logic [READS_W-1:0] READS_FULL = 3'd7;
   localparam logic [READS_W-1:0] READS_NONE = 3'd0;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_NOCONN = 2'd3
   } status_type;

   typedef enum logic {
      REQ_PUT = 1'b0,
      REQ_GET = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic data_we;
      logic reads_we;
   } wr_ctl_type;

endpackage

>>> src/brb_slot_mem.sv
// ----------------------------------------------------------------------------
// brb_slot_mem
// Slot word memory and slot read-count memory, one shared read address,
// one shared write address, registered read data.
// ----------------------------------------------------------------------------
module brb_slot_mem #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned WORD_WIDTH = 32,
   parameter int unsigned AW         = 4
) (
   input  logic                        clock,
   input  logic [AW-1:0]               rd_addr,
   output logic [WORD_WIDTH-1:0]       rd_data,
   output logic [brb_pkg::READS_W-1:0] rd_reads,
   input  logic [AW-1:0]               wr_addr,
   input  brb_pkg::wr_ctl_type         wr_ctl,
   input  logic [WORD_WIDTH-1:0]       wr_data,
   input  logic [brb_pkg::READS_W-1:0] wr_reads
);
   import brb_pkg::*;

   logic [WORD_WIDTH-1:0] data_mem  [DEPTH];
   logic [READS_W-1:0]    reads_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_ctl.data_we) begin
         data_mem[wr_addr] <= wr_data;
      end
      rd_data <= data_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.reads_we) begin
         reads_mem[wr_addr] <= wr_reads;
      end
      rd_reads <= reads_mem[rd_addr];
   end

endmodule

>>> src/broadcast_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// broadcast_ring_buffer_unit
// Ring buffer that hands every put word to each connected reader.
//
// Request channel (req_*): a put (req_type = put) stores req_write_word; a
// get (req_type = get) returns the next word for reader req_reader_id.
// Response channel (rsp_*): exactly one word per request with a status,
// the returned word and the slot used. A refused request changes nothing.
// csr_we/csr_wdata write the connected reader count; write it only while
// no request is in flight.
// A request first reads the synchronous slot memory, then updates the slot
// and loads the response register. A new request is taken only once the
// previous one has finished; the response register lets the next request
// enter while a response still waits under rsp_stall.
// After reset the read counts of all slots are swept to fully read, one
// slot per cycle: req_stall stays high until the sweep ends.
// A held response stalls completion of the next request until taken.
// ----------------------------------------------------------------------------
module broadcast_ring_buffer_unit #(
   parameter int unsigned DEPTH       = 16,
   parameter int unsigned MAX_READERS = 4,
   parameter int unsigned WORD_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [brb_pkg::RID_W-1:0]       req_reader_id,
   input  logic [brb_pkg::FIELD_W-1:0]     req_write_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [brb_pkg::STATUS_W-1:0]    rsp_status,
   output logic [brb_pkg::FIELD_W-1:0]     rsp_read_word,
   output logic [brb_pkg::SLOT_USED_W-1:0] rsp_slot_used,
   input  logic                            csr_we,
   input  logic [brb_pkg::COUNT_W-1:0]     csr_wdata
);
   import brb_pkg::*;

   localparam int unsigned AW     = $clog2(DEPTH);
   localparam int unsigned RIDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [AW-1:0]         wp_ff;
   logic [AW-1:0]         rp_ff [MAX_READERS];
   req_kind_type          kind_ff;
   logic                  noconn_ff;
   logic [RIDX_W-1:0]     ridx_ff;
   logic [FIELD_W-1:0]    word_ff;
   logic [AW-1:0]         addr_ff;
   logic                  rsp_valid_ff;
   status_type            status_ff;
   logic [FIELD_W-1:0]    rword_ff;
   logic [SLOT_USED_W-1:0] slot_ff;

   logic                  accept;
   logic                  finish;
   logic [COUNT_W-1:0]    n_eff;
   logic [RIDX_W+1:0]     rid_wide;
   logic [RIDX_W-1:0]     ridx;
   logic                  rid_in_range;
   logic [AW-1:0]         lookup_addr;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         next_addr;
   logic [WORD_WIDTH-1:0] rd_data;
   logic [READS_W-1:0]    rd_reads;
   logic                  put_ok;
   logic                  get_ok;
   wr_ctl_type            wr_ctl;
   logic [AW-1:0]         wr_addr;
   logic [READS_W-1:0]    wr_reads;
   logic [AW+SLOT_USED_W-1:0] slot_wide;
   status_type            status_in;

   // effective reader count
   always_comb begin
      if (32'(count_ff) > MAX_READERS) begin
         n_eff = COUNT_W'(MAX_READERS);
      end else begin
         n_eff = count_ff;
      end
   end

   assign rid_wide     = (RIDX_W+2)'(req_reader_id);
   assign ridx         = rid_wide[RIDX_W-1:0];
   assign rid_in_range = 32'(req_reader_id) < MAX_READERS;

   always_comb begin
      if (req_type == REQ_PUT) begin
         lookup_addr = wp_ff;
      end else if (rid_in_range) begin
         lookup_addr = rp_ff[ridx];
      end else begin
         lookup_addr = '0;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = accept ? lookup_addr : addr_ff;
   assign next_addr = (addr_ff == AW'(DEPTH-1)) ? '0 : addr_ff + AW'(1);

   assign put_ok = (kind_ff == REQ_PUT) && (rd_reads >= n_eff);
   assign get_ok = (kind_ff == REQ_GET) && !noconn_ff && (rd_reads < n_eff);
   assign finish = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      wr_ctl   = '0;
      wr_addr  = addr_ff;
      wr_reads = READS_NONE;
      if (state_ff == S_CLEAR) begin
         wr_ctl.reads_we = 1'b1;
         wr_addr         = clr_ff;
         wr_reads        = READS_FULL;
      end else if (finish && put_ok) begin
         wr_ctl.data_we  = 1'b1;
         wr_ctl.reads_we = 1'b1;
      end else if (finish && get_ok) begin
         wr_ctl.reads_we = 1'b1;
         wr_reads        = (rd_reads < READS_FULL) ? rd_reads + READS_W'(1) : rd_reads;
      end
   end

   brb_slot_mem #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .AW         (AW)
   ) u_slot_mem (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rd_reads (rd_reads),
      .wr_addr  (wr_addr),
      .wr_ctl   (wr_ctl),
      .wr_data  (WORD_WIDTH'(word_ff)),
      .wr_reads (wr_reads)
   );

   always_comb begin
      if (kind_ff == REQ_PUT) begin
         status_in = put_ok ? ST_DONE : ST_FULL;
      end else if (noconn_ff) begin
         status_in = ST_NOCONN;
      end else begin
         status_in = get_ok ? ST_DONE : ST_EMPTY;
      end
   end

   assign slot_wide = (AW+SLOT_USED_W)'(addr_ff);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= COUNT_W'(1);
         wp_ff    <= '0;
         for (int i = 0; i < MAX_READERS; i++) begin
            rp_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         if (finish && put_ok) begin
            wp_ff <= next_addr;
         end
         if (finish && get_ok) begin
            rp_ff[ridx_ff] <= next_addr;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the request and the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind_type'(req_type);
         noconn_ff <= ({1'b0, req_reader_id} >= n_eff) || !rid_in_range;
         ridx_ff   <= ridx;
         word_ff   <= req_write_word;
         addr_ff   <= lookup_addr;
      end
      if (finish) begin
         status_ff <= status_in;
         rword_ff  <= get_ok ? FIELD_W'(rd_data) : '0;
         slot_ff   <= (put_ok || get_ok) ? slot_wide[SLOT_USED_W-1:0] : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_read_word = rword_ff;
   assign rsp_slot_used = slot_ff;

`ifndef SYNTHESIS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not start execution");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("request accepted during clearing pass");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |-> (rsp_read_word == '0 && rsp_slot_used == '0))
      else $error("refused request carries a word or slot");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("finished request produced no response");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the broadcast ring buffer unit. A fixed script
// covers empty and unconnected readers, word extremes, a zero reader count
// and a clamped one. Random phases at several reader counts follow.
// Each response is checked field by field against a fixed script answer or
// an in-bench model of the slot state. Both channels idle and stall at
// random, and one long response hold backs the buffer up into its input.
// ----------------------------------------------------------------------------
module tb;
   import brb_pkg::*;

   localparam int unsigned DEPTH        = 16;
   localparam int unsigned MAX_READERS  = 4;
   localparam int unsigned HALF_PERIOD  = 5;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned GAP_MAX      = 14;
   localparam int unsigned HOLD_CYCLES  = 90;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned QUIET_LIMIT  = 1000;
   localparam int unsigned SHOWN_MAX    = 10;
   localparam int unsigned PHASES       = 10;
   localparam int unsigned PHASE_WORDS  = 64;
   localparam int unsigned HOLD_PHASE   = 1;
   localparam int unsigned HOLD_WORD    = 20;
   localparam int unsigned SCRIPT_LEN   = 24;

   typedef enum logic [1:0] {
      ROW_PUT,
      ROW_GET,
      ROW_CFG
   } row_kind_type;

   typedef struct packed {
      status_type               status;
      logic [FIELD_W-1:0]       word;
      logic [SLOT_USED_W-1:0]   slot;
   } answer_type;

   typedef struct packed {
      logic       fixed;
      answer_type ans;
   } note_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [RID_W-1:0]   rid;
      logic [FIELD_W-1:0] word;
      logic               fixed;
      answer_type         ans;
   } row_type;

   localparam answer_type NO_ANS = '{ST_DONE, 32'h0, 4'd0};

   localparam row_type SCRIPT [SCRIPT_LEN] = '{
      '{ROW_GET, 2'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY,  32'h0000_0000, 4'd0}},
      '{ROW_GET, 2'd1, 32'h0000_0000, 1'b1, '{ST_NOCONN, 32'h0000_0000, 4'd0}},
      '{ROW_GET, 2'd3, 32'h0000_0000, 1'b1, '{ST_NOCONN, 32'h0000_0000, 4'd0}},
      '{ROW_PUT, 2'd0, 32'h0000_0000, 1'b1, '{ST_DONE,   32'h0000_0000, 4'd0}},
      '{ROW_PUT, 2'd2, 32'hFFFF_FFFF, 1'b1, '{ST_DONE,   32'h0000_0000, 4'd1}},
      '{ROW_GET, 2'd0, 32'h0000_0000, 1'b1, '{ST_DONE,   32'h0000_0000, 4'd0}},
      '{ROW_GET, 2'd0, 32'hFFFF_FFFF, 1'b1, '{ST_DONE,   32'hFFFF_FFFF, 4'd1}},
      '{ROW_GET, 2'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY,  32'h0000_0000, 4'd0}},
      '{ROW_CFG, 2'd0, 32'd0,         1'b0, NO_ANS},
      '{ROW_PUT, 2'd1, 32'hA5A5_A5A5, 1'b1, '{ST_DONE,   32'h0000_0000, 4'd2}},
      '{ROW_GET, 2'd0, 32'h0000_0000, 1'b1, '{ST_NOCONN, 32'h0000_0000, 4'd0}},
      '{ROW_GET, 2'd3, 32'h0000_0000, 1'b1, '{ST_NOCONN, 32'h0000_0000, 4'd0}},
      '{ROW_CFG, 2'd0, 32'd7,         1'b0, NO_ANS},
      '{ROW_PUT, 2'd0, 32'h5A5A_5A5A, 1'b1, '{ST_DONE,   32'h0000_0000, 4'd3}},
      '{ROW_GET, 2'd0, 32'h0000_0000, 1'b1, '{ST_DONE,   32'hA5A5_A5A5, 4'd2}},
      '{ROW_GET, 2'd3, 32'h0000_0000, 1'b0, NO_ANS},
      '{ROW_GET, 2'd2, 32'h0000_0000, 1'b0, NO_ANS},
      '{ROW_GET, 2'd1, 32'h0000_0000, 1'b0, NO_ANS},
      '{ROW_CFG, 2'd0, 32'd4,         1'b0, NO_ANS},
      '{ROW_PUT, 2'd3, 32'h1234_5678, 1'b0, NO_ANS},
      '{ROW_GET, 2'd3, 32'h0000_0000, 1'b0, NO_ANS},
      '{ROW_CFG, 2'd0, 32'd5,         1'b0, NO_ANS},
      '{ROW_PUT, 2'd0, 32'hFEDC_BA98, 1'b0, NO_ANS},
      '{ROW_GET, 2'd2, 32'h0000_0000, 1'b0, NO_ANS}
   };

   localparam logic [COUNT_W-1:0] PHASE_COUNTS [PHASES] = '{
      3'd1, 3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd4, 3'd6, 3'd1
   };

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic                     req_type       = 1'b0;
   logic [RID_W-1:0]         req_reader_id  = '0;
   logic [FIELD_W-1:0]       req_write_word = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [FIELD_W-1:0]       rsp_read_word;
   logic [SLOT_USED_W-1:0]   rsp_slot_used;
   logic                     csr_we         = 1'b0;
   logic [COUNT_W-1:0]       csr_wdata      = '0;

   logic [FIELD_W-1:0]       slot_word  [DEPTH];
   logic [READS_W-1:0]       slot_taken [DEPTH];
   logic [3:0]               put_ptr;
   logic [3:0]               take_ptr   [MAX_READERS];
   logic [COUNT_W-1:0]       readers_cfg;

   answer_type               due_answers [$];
   note_type                 typed_answers [$];
   int unsigned              mismatches  = 0;
   int unsigned              quiet_cycles = 0;
   int unsigned              send_burst  = 0;
   int unsigned              take_burst  = 0;
   logic                     hold_rsp    = 1'b0;

   broadcast_ring_buffer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_reader_id  (req_reader_id),
      .req_write_word (req_write_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_word  (rsp_read_word),
      .rsp_slot_used  (rsp_slot_used),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic answer_type serve_request(logic kind, logic [RID_W-1:0] rid,
                                                logic [FIELD_W-1:0] word);
      answer_type  ans;
      int unsigned live;
      logic [3:0]  p;
      ans  = NO_ANS;
      live = (readers_cfg > MAX_READERS) ? MAX_READERS : readers_cfg;
      if (req_kind_type'(kind) == REQ_PUT) begin
         p = put_ptr;
         if (slot_taken[p] >= live) begin
            slot_word[p]  = word;
            slot_taken[p] = READS_NONE;
            put_ptr       = p + 4'd1;
            ans.slot      = p;
         end else begin
            ans.status = ST_FULL;
         end
      end else if (rid >= live) begin
         ans.status = ST_NOCONN;
      end else begin
         p = take_ptr[rid];
         if (slot_taken[p] < live) begin
            ans.word = slot_word[p];
            if (slot_taken[p] != READS_FULL) begin
               slot_taken[p] = slot_taken[p] + 3'd1;
            end
            take_ptr[rid] = p + 4'd1;
            ans.slot      = p;
         end else begin
            ans.status = ST_EMPTY;
         end
      end
      return ans;
   endfunction

   function automatic int unsigned draw_gap(inout int unsigned burst_left);
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   task automatic offer_word(req_kind_type kind, logic [RID_W-1:0] rid,
                             logic [FIELD_W-1:0] word, logic fixed, answer_type ans);
      int unsigned gap;
      gap = draw_gap(send_burst);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_answers.push_back('{fixed, ans});
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_reader_id  <= rid;
      req_write_word <= word;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
   endtask

   task automatic set_readers(logic [COUNT_W-1:0] count);
      req_valid <= 1'b0;
      @(negedge clock);
      while (due_answers.size() != 0) @(negedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : req_side
      int unsigned      put_pct;
      int unsigned      live;
      req_kind_type     kind;
      logic [RID_W-1:0] rid;
      for (int i = 0; i < DEPTH; i++) begin
         slot_word[i]  = '0;
         slot_taken[i] = READS_FULL;
      end
      for (int i = 0; i < MAX_READERS; i++) begin
         take_ptr[i] = '0;
      end
      put_ptr     = '0;
      readers_cfg = 3'd1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[r]) begin
         if (SCRIPT[r].kind == ROW_CFG) begin
            set_readers(SCRIPT[r].word[COUNT_W-1:0]);
         end else begin
            offer_word((SCRIPT[r].kind == ROW_PUT) ? REQ_PUT : REQ_GET, SCRIPT[r].rid,
                       SCRIPT[r].word, SCRIPT[r].fixed, SCRIPT[r].ans);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         set_readers(PHASE_COUNTS[ph]);
         put_pct = $urandom_range(25, 75);
         live    = (PHASE_COUNTS[ph] > MAX_READERS) ? MAX_READERS : PHASE_COUNTS[ph];
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (ph == HOLD_PHASE && k == HOLD_WORD) begin
               hold_rsp = 1'b1;
            end
            kind = ($urandom_range(1, 100) <= put_pct) ? REQ_PUT : REQ_GET;
            if (live != 0 && $urandom_range(0, 4) != 0) begin
               rid = RID_W'($urandom_range(0, live - 1));
            end else begin
               rid = RID_W'($urandom_range(0, 3));
            end
            offer_word(kind, rid, $urandom, 1'b0, NO_ANS);
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (due_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_answers.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : rsp_side
      int unsigned wait_cycles;
      forever begin
         wait_cycles = draw_gap(take_burst);
         // hold off long enough to back the buffer up into its input
         if (hold_rsp) begin
            hold_rsp    = 1'b0;
            wait_cycles = HOLD_CYCLES;
         end
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_side
      answer_type seen;
      answer_type want;
      answer_type model;
      note_type   note;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{status_type'(rsp_status), rsp_read_word, rsp_slot_used};
            if (due_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MAX) begin
                  $display("unexpected word: status %0d data %h slot %0d",
                           seen.status, seen.word, seen.slot);
               end
            end else begin
               want = due_answers.pop_front();
               if (seen.status !== want.status || seen.word !== want.word ||
                   seen.slot !== want.slot) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MAX) begin
                     $display("mismatch: want status %0d data %h slot %0d, got status %0d data %h slot %0d",
                              want.status, want.word, want.slot,
                              seen.status, seen.word, seen.slot);
                  end
               end
            end
         end
         if (csr_we) begin
            readers_cfg = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            model = serve_request(req_type, req_reader_id, req_write_word);
            note  = typed_answers.pop_front();
            due_answers.push_back(note.fixed ? note.ans : model);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no word moved in %0d cycles", QUIET_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

>>> files.f
src/brb_pkg.sv
src/brb_slot_mem.sv
src/broadcast_ring_buffer_unit.sv
verif/tb.sv
